/* sv/psd_pkg.sv */
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int OUT_BITS     = 43;
  localparam int CFG_IDX_BITS = 8;

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int MAG_BITS  = PROD_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int NUM_BITS  = SQ_BITS + FRAC_BITS + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 8'd0,
    REG_START_Y = 8'd1,
    REG_END_X   = 8'd2,
    REG_END_Y   = 8'd3
  } cfg_reg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                degen;
    logic                between;
    logic [MAG_BITS-1:0] ep;
    logic [MAG_BITS-1:0] c;
    logic [MAG_BITS-1:0] len2;
  } psd_item_t;

endpackage
`default_nettype wire

/* sv/psd_in_if.sv */
`default_nettype none
interface psd_in_if import psd_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface
`default_nettype wire

/* sv/psd_out_if.sv */
`default_nettype none
interface psd_out_if import psd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] square_distance;
  logic                degenerate;
  modport source (output valid, square_distance, degenerate, input ready);
  modport sink   (input valid, square_distance, degenerate, output ready);
endinterface
`default_nettype wire

/* sv/psd_cfg_if.sv */
`default_nettype none
interface psd_cfg_if import psd_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/point_segment_square_distance_unit.sv */
`default_nettype none
// channel  dir  payload                              handshake
// in_ch    in   point_x[16] s, point_y[16] s         valid/ready
// out_ch   out  square_distance[43] u, degenerate    valid/ready
// cfg_ch   in   index[8], data[16]                   valid/ready
// One request per cycle sustained while out_ch is ready; requests pass the
// front, the queue, the back and a divider (one quotient bit per stage).
// rst_n is synchronous; segment registers reset to zero.
// Front and back stall independently across a four-entry queue;
// out_ch stalls freeze the back pipeline, a full queue blocking a push freezes the front.
module point_segment_square_distance_unit import psd_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch,
  psd_cfg_if.sink   cfg_ch
);

  logic      push, pop, full, empty;
  psd_item_t push_item, head;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .fifo_full (full),
    .push      (push),
    .item      (push_item)
  );

  psd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  psd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

/* sv/psd_front.sv */
`default_nettype none
module psd_front import psd_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  psd_in_if.sink       in_ch,
  psd_cfg_if.sink      cfg_ch,
  input  wire          fifo_full,
  output logic         push,
  output psd_item_t    item
);

  logic signed [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic                         en;
  logic                         s1_v_r, s2_v_r, s3_v_r;
  logic signed [DIFF_BITS-1:0]  ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic signed [PROD_BITS-1:0]  axax_r, ayay_r, bxbx_r, byby_r, dxdx_r, dydy_r;
  logic signed [PROD_BITS-1:0]  axdx_r, aydy_r, axdy_r, aydx_r;
  logic [MAG_BITS-1:0]          len2_r, a2_r, b2_r;
  logic signed [SUM_BITS-1:0]   dot_r, cross_r, cross_abs;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ex_r <= '0;
      ey_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_START_X: sx_r <= cfg_ch.data;
        REG_START_Y: sy_r <= cfg_ch.data;
        REG_END_X:   ex_r <= cfg_ch.data;
        REG_END_Y:   ey_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign en          = !(s3_v_r && fifo_full);
  assign in_ch.ready = en;
  assign push        = s3_v_r && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= DIFF_BITS'(in_ch.point_x) - DIFF_BITS'(sx_r);
      ay_r    <= DIFF_BITS'(in_ch.point_y) - DIFF_BITS'(sy_r);
      bx_r    <= DIFF_BITS'(in_ch.point_x) - DIFF_BITS'(ex_r);
      by_r    <= DIFF_BITS'(in_ch.point_y) - DIFF_BITS'(ey_r);
      dx_r    <= DIFF_BITS'(ex_r) - DIFF_BITS'(sx_r);
      dy_r    <= DIFF_BITS'(ey_r) - DIFF_BITS'(sy_r);
      axax_r  <= ax_r * ax_r;
      ayay_r  <= ay_r * ay_r;
      bxbx_r  <= bx_r * bx_r;
      byby_r  <= by_r * by_r;
      dxdx_r  <= dx_r * dx_r;
      dydy_r  <= dy_r * dy_r;
      axdx_r  <= ax_r * dx_r;
      aydy_r  <= ay_r * dy_r;
      axdy_r  <= ax_r * dy_r;
      aydx_r  <= ay_r * dx_r;
      len2_r  <= MAG_BITS'(dxdx_r) + MAG_BITS'(dydy_r);
      a2_r    <= MAG_BITS'(axax_r) + MAG_BITS'(ayay_r);
      b2_r    <= MAG_BITS'(bxbx_r) + MAG_BITS'(byby_r);
      dot_r   <= SUM_BITS'(axdx_r) + SUM_BITS'(aydy_r);
      cross_r <= SUM_BITS'(axdy_r) - SUM_BITS'(aydx_r);
    end
  end

  assign cross_abs = cross_r[SUM_BITS-1] ? -cross_r : cross_r;

  always_comb begin
    item.degen   = 1'b0;
    item.between = 1'b0;
    item.ep      = a2_r;
    item.c       = cross_abs[MAG_BITS-1:0];
    item.len2    = len2_r;
    priority if (len2_r == '0) begin
      item.degen = 1'b1;
    end else if (dot_r <= 0) begin
      item.ep = a2_r;
    end else if (dot_r >= $signed({1'b0, len2_r})) begin
      item.ep = b2_r;
    end else begin
      item.between = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/psd_fifo.sv */
`default_nettype none
module psd_fifo import psd_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  psd_item_t  push_item,
  input  wire        pop,
  output logic       full,
  output logic       empty,
  output psd_item_t  head
);

  psd_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_item;
  end

endmodule
`default_nettype wire

/* sv/psd_back.sv */
`default_nettype none
module psd_back import psd_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        empty,
  input  psd_item_t  head,
  output logic       pop,
  psd_out_if.source  out_ch
);

  logic                en;
  logic                m_v_r;
  psd_item_t           m_item_r;
  logic [SQ_BITS-1:0]  m_sq_r;
  logic [NUM_BITS-1:0] num;

  logic                v_r   [OUT_BITS+1];
  logic [MAG_BITS-1:0] rem_r [OUT_BITS+1];
  logic [OUT_BITS-1:0] w_r   [OUT_BITS+1];
  logic [MAG_BITS-1:0] d_r   [OUT_BITS+1];
  logic [MAG_BITS-1:0] ep_r  [OUT_BITS+1];
  logic                btw_r [OUT_BITS+1];
  logic                dg_r  [OUT_BITS+1];

  assign en  = !v_r[OUT_BITS] || out_ch.ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r  <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      m_v_r  <= !empty;
      v_r[0] <= m_v_r;
    end
  end

  // numerator c^2 * 2^FRAC + len2/2, rounding half up
  assign num = (NUM_BITS'(m_sq_r) << FRAC_BITS) + NUM_BITS'(m_item_r.len2 >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      m_item_r <= head;
      m_sq_r   <= head.c * head.c;
      rem_r[0] <= num[NUM_BITS-1:OUT_BITS];
      w_r[0]   <= num[OUT_BITS-1:0];
      d_r[0]   <= m_item_r.len2;
      ep_r[0]  <= m_item_r.ep;
      btw_r[0] <= m_item_r.between;
      dg_r[0]  <= m_item_r.degen;
    end
  end

  for (genvar i = 0; i < OUT_BITS; i++) begin : g_div
    logic [MAG_BITS:0]   trial;
    logic                ge;
    logic [MAG_BITS:0]   diff;
    logic [MAG_BITS-1:0] rem_nxt;
    logic [OUT_BITS-1:0] w_nxt;

    always_comb begin
      trial   = {rem_r[i], w_r[i][OUT_BITS-1]};
      ge      = trial >= {1'b0, d_r[i]};
      diff    = trial - {1'b0, d_r[i]};
      rem_nxt = ge ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
      w_nxt   = {w_r[i][OUT_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        w_r[i+1]   <= w_nxt;
        d_r[i+1]   <= d_r[i];
        ep_r[i+1]  <= ep_r[i];
        btw_r[i+1] <= btw_r[i];
        dg_r[i+1]  <= dg_r[i];
      end
    end
  end

  assign out_ch.valid           = v_r[OUT_BITS];
  assign out_ch.degenerate      = dg_r[OUT_BITS];
  assign out_ch.square_distance = btw_r[OUT_BITS] ? w_r[OUT_BITS]
                                  : (OUT_BITS'(ep_r[OUT_BITS]) << FRAC_BITS);

endmodule
`default_nettype wire
